### design/sstq_pkg.sv
// sstq_pkg: shared widths, codes and types of the sorted sleep timer queue
// no dependencies; imported by every other file of the block
package sstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int FUNC_W     = 2;
  localparam int TID_W      = 8;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int TICK_W     = 64;
  localparam int KIND_W     = 3;
  localparam int TPM_W      = 10;
  localparam int PER_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // seconds to microseconds
  localparam int                  USEC_W     = 20;
  localparam logic [USEC_W-1:0]   US_PER_SEC = 20'd1000000;
  localparam int                  SECUS_W    = SEC_W + USEC_W;

  // nanoseconds / 1000 by reciprocal multiply, exact for values below 2^30
  localparam int                  RECIP_W    = 31;
  localparam logic [RECIP_W-1:0]  NS_RECIP   = 31'd1099511628;
  localparam int                  NS_SHIFT   = 40;
  localparam int                  NSPROD_W   = NSEC_W + RECIP_W;
  localparam int                  NSQ_W      = 21;

  localparam int US_W    = SECUS_W + 1;
  localparam int TPMUL_W = US_W + TPM_W;

  typedef enum logic [FUNC_W-1:0] {
    F_ENQ    = 2'd0,
    F_CANCEL = 2'd1,
    F_TIMER  = 2'd2,
    F_NONE   = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    K_WOKEN    = 3'd0,
    K_ENQ      = 3'd1,
    K_FULL     = 3'd2,
    K_CANCEL   = 3'd3,
    K_NOTFOUND = 3'd4,
    K_REARM    = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPM    = 2'd0,
    CFG_PERIOD = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_CANCEL = 2'd2,
    CH_POP    = 2'd3
  } chain_op_e;

  typedef struct packed {
    logic               valid;
    logic [TICK_W-1:0]  tick;
    logic [ID_BITS-1:0] id;
  } cell_data_t;

  typedef struct packed {
    chain_op_e          op;
    logic [TICK_W-1:0]  tick;
    logic [ID_BITS-1:0] id;
  } chain_cmd_t;

endpackage

### design/sstq_in_if.sv
// sstq_in_if: request channel of the sorted sleep timer queue
// depends on sstq_pkg
interface sstq_in_if import sstq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0]  thread_id;
  logic [SEC_W-1:0]  timeout_sec;
  logic [NSEC_W-1:0] timeout_nsec;
  logic [TICK_W-1:0] now_tick;

  modport source (output valid, func, thread_id, timeout_sec, timeout_nsec, now_tick,
                  input ready);
  modport sink   (input valid, func, thread_id, timeout_sec, timeout_nsec, now_tick,
                  output ready);
endinterface

### design/sstq_out_if.sv
// sstq_out_if: result channel of the sorted sleep timer queue
// depends on sstq_pkg
interface sstq_out_if import sstq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  woken_id;
  logic              set_timer;
  logic [TICK_W-1:0] timer_delay;
  logic              last;

  modport source (output valid, kind, woken_id, set_timer, timer_delay, last,
                  input ready);
  modport sink   (input valid, kind, woken_id, set_timer, timer_delay, last,
                  output ready);
endinterface

### design/sstq_cfg_if.sv
// sstq_cfg_if: register write channel of the sorted sleep timer queue
// depends on sstq_pkg
interface sstq_cfg_if import sstq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/sstq_cell.sv
// sstq_cell: one slot of the sorted chain, holds a sleeper and trades with its neighbors
// depends on sstq_pkg
module sstq_cell import sstq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_cmd_t cmd_i,
  input  cell_data_t prev_i,
  input  logic       prev_ge_i,
  input  cell_data_t next_i,
  input  logic       hit_i,
  output cell_data_t data_o,
  output logic       ge_o,
  output logic       hit_o
);

  logic               valid_q, valid_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic               match;

  assign data_o = '{valid: valid_q, tick: tick_q, id: id_q};
  // slot holds nothing due at or before the new tick
  assign ge_o   = !(valid_q && (tick_q <= cmd_i.tick));
  assign match  = valid_q && (id_q == cmd_i.id);
  assign hit_o  = hit_i || match;

  always_comb begin
    valid_d = valid_q;
    tick_d  = tick_q;
    id_d    = id_q;
    case (cmd_i.op)
      CH_INSERT: begin
        if (ge_o) begin
          if (prev_ge_i) begin
            valid_d = prev_i.valid;
            tick_d  = prev_i.tick;
            id_d    = prev_i.id;
          end else begin
            valid_d = 1'b1;
            tick_d  = cmd_i.tick;
            id_d    = cmd_i.id;
          end
        end
      end
      CH_CANCEL: begin
        if (hit_o) begin
          valid_d = next_i.valid;
          tick_d  = next_i.tick;
          id_d    = next_i.id;
        end
      end
      CH_POP: begin
        valid_d = next_i.valid;
        tick_d  = next_i.tick;
        id_d    = next_i.id;
      end
      CH_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q <= tick_d;
    id_q   <= id_d;
  end

endmodule

### design/sstq_chain.sv
// sstq_chain: row of sstq_cell slots kept sorted by wakeup tick, earliest at the head
// depends on sstq_pkg and sstq_cell
module sstq_chain import sstq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_cmd_t cmd_i,
  output cell_data_t head_o,
  output logic       full_o,
  output logic       found_o
);

  cell_data_t data [QUEUE_DEPTH];
  cell_data_t prev [QUEUE_DEPTH];
  cell_data_t next [QUEUE_DEPTH];
  logic       ge   [QUEUE_DEPTH];
  logic       pge  [QUEUE_DEPTH];
  logic       hin  [QUEUE_DEPTH];
  logic       hout [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev[i] = '0;
      assign pge[i]  = 1'b0;
      assign hin[i]  = 1'b0;
    end else begin : g_mid
      assign prev[i] = data[i-1];
      assign pge[i]  = ge[i-1];
      assign hin[i]  = hout[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next[i] = '0;
    end else begin : g_inner
      assign next[i] = data[i+1];
    end

    sstq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .prev_i    (prev[i]),
      .prev_ge_i (pge[i]),
      .next_i    (next[i]),
      .hit_i     (hin[i]),
      .data_o    (data[i]),
      .ge_o      (ge[i]),
      .hit_o     (hout[i])
    );
  end

  assign head_o  = data[0];
  assign full_o  = data[QUEUE_DEPTH-1].valid;
  assign found_o = hout[QUEUE_DEPTH-1];

endmodule

### design/sorted_sleep_timer_queue_core.sv
// sorted_sleep_timer_queue_core: sorted sleeper queue with tick conversion and timer re-arm
// depends on sstq_pkg, the three channel interfaces and sstq_chain
// from accept to result: enqueue passes two multiplier stages, a sum and the wake add,
// then inserts; full and cancel answer directly; timer pops each due sleeper, then re-arms;
// results wait while one is held; one item in work, next taken after its final result
// async active-low reset empties the queue, next expiry 0, registers to 1 and 10000
module sorted_sleep_timer_queue_core import sstq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  sstq_in_if.sink    in_i,
  sstq_out_if.source out_o,
  sstq_cfg_if.sink   cfg_i
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_FULL = 11'b00000000010,
    S_MUL  = 11'b00000000100,
    S_SUM  = 11'b00000001000,
    S_TPM  = 11'b00000010000,
    S_WAKE = 11'b00000100000,
    S_INS  = 11'b00001000000,
    S_CAN  = 11'b00010000000,
    S_POP  = 11'b00100000000,
    S_RA1  = 11'b01000000000,
    S_RA2  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [TPM_W-1:0]   tpm_q;
  logic [PER_W-1:0]   period_q;
  logic [TICK_W-1:0]  next_exp_q, next_exp_d;

  logic [ID_BITS-1:0] id_q;
  logic [SEC_W-1:0]   sec_q;
  logic [NSEC_W-1:0]  nsec_q;
  logic [TICK_W-1:0]  now_q;
  logic [SECUS_W-1:0] secus_q;
  logic [NSQ_W-1:0]   nsq_q;
  logic [US_W-1:0]    us_q;
  logic [TICK_W-1:0]  ticks_q;
  logic [TICK_W-1:0]  wake_q;
  logic [TICK_W-1:0]  sum_q;
  logic [TICK_W-1:0]  diff_q;
  logic               hn_gt_q;

  logic [NSPROD_W-1:0] ns_prod;
  logic [TPMUL_W-1:0]  tpm_prod;

  logic               out_valid_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [TID_W-1:0]   out_id_q;
  logic               out_set_q;
  logic [TICK_W-1:0]  out_delay_q;
  logic               out_last_q;

  logic               out_free;
  logic               emit;
  kind_e              e_kind;
  logic [ID_BITS-1:0] e_id;
  logic               e_set;
  logic [TICK_W-1:0]  e_delay;
  logic               e_last;

  chain_cmd_t         cmd;
  cell_data_t         head;
  logic               full;
  logic               found;
  logic               in_acc;
  logic               ra_gt;

  sstq_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .head_o  (head),
    .full_o  (full),
    .found_o (found)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  assign ns_prod  = NSPROD_W'(nsec_q) * NSPROD_W'(NS_RECIP);
  assign tpm_prod = TPMUL_W'(us_q) * TPMUL_W'(tpm_q);
  assign ra_gt    = head.valid && (sum_q > head.tick);

  always_comb begin
    state_d    = state_q;
    next_exp_d = next_exp_q;
    cmd        = '{op: CH_HOLD, tick: wake_q, id: id_q};
    emit       = 1'b0;
    e_kind     = K_ENQ;
    e_id       = id_q;
    e_set      = 1'b0;
    e_delay    = '0;
    e_last     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.func)
            F_ENQ:    state_d = full ? S_FULL : S_MUL;
            F_CANCEL: state_d = S_CAN;
            F_TIMER:  state_d = S_POP;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_FULL: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = K_FULL;
          state_d = S_IDLE;
        end
      end
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_TPM;
      S_TPM:  state_d = S_WAKE;
      S_WAKE: state_d = S_INS;
      S_INS: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = K_ENQ;
          cmd.op = CH_INSERT;
          if (next_exp_q > wake_q) begin
            next_exp_d = wake_q;
            e_set      = 1'b1;
            e_delay    = ticks_q;
          end
          state_d = S_IDLE;
        end
      end
      S_CAN: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = found ? K_CANCEL : K_NOTFOUND;
          cmd.op  = CH_CANCEL;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (head.valid && (head.tick <= now_q)) begin
          if (out_free) begin
            emit   = 1'b1;
            e_kind = K_WOKEN;
            e_id   = head.id;
            e_last = 1'b0;
            cmd.op = CH_POP;
          end
        end else begin
          state_d = S_RA1;
        end
      end
      S_RA1: state_d = S_RA2;
      S_RA2: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = K_REARM;
          e_id   = '0;
          e_set  = 1'b1;
          if (ra_gt) begin
            e_delay    = hn_gt_q ? diff_q : '0;
            next_exp_d = hn_gt_q ? head.tick : now_q;
          end else begin
            e_delay    = TICK_W'(period_q);
            next_exp_d = sum_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_exp_q  <= '0;
      tpm_q       <= TPM_W'(1);
      period_q    <= PER_W'(10000);
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_exp_q <= next_exp_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_TPM:    tpm_q    <= cfg_i.data[TPM_W-1:0];
          CFG_PERIOD: period_q <= cfg_i.data[PER_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q   <= ID_BITS'(in_i.thread_id);
      sec_q  <= in_i.timeout_sec;
      nsec_q <= in_i.timeout_nsec;
      now_q  <= in_i.now_tick;
    end
    secus_q <= SECUS_W'(sec_q) * SECUS_W'(US_PER_SEC);
    nsq_q   <= ns_prod[NS_SHIFT +: NSQ_W];
    us_q    <= US_W'(secus_q) + US_W'(nsq_q);
    ticks_q <= TICK_W'(tpm_prod);
    wake_q  <= now_q + ticks_q;
    sum_q   <= now_q + TICK_W'(period_q);
    diff_q  <= head.tick - now_q;
    hn_gt_q <= head.tick > now_q;
    if (emit) begin
      out_kind_q  <= e_kind;
      out_id_q    <= TID_W'(e_id);
      out_set_q   <= e_set;
      out_delay_q <= e_delay;
      out_last_q  <= e_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.woken_id    = out_id_q;
  assign out_o.set_timer   = out_set_q;
  assign out_o.timer_delay = out_delay_q;
  assign out_o.last        = out_last_q;

endmodule

### design/sstq_checker.sv
// sstq_checker: port-level assertions for sorted_sleep_timer_queue_core
// depends on sstq_pkg; bound to the top level at the end of this file
module sstq_checker import sstq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic              out_set,
  input logic [TICK_W-1:0] out_delay,
  input logic              out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // only woken items continue a sequence, everything else closes it
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_kind != K_WOKEN)))
    else $error("last flag does not match kind");

  a_rearm_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == K_REARM) |-> out_set)
    else $error("rearm without set_timer");

  a_delay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_set |-> (out_delay == '0))
    else $error("delay given without set_timer");

  // one item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_func != F_NONE) |=> !in_ready)
    else $error("new item taken while busy");

endmodule

bind sorted_sleep_timer_queue_core sstq_checker u_sstq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_func   (in_i.func),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_set   (out_o.set_timer),
  .out_delay (out_o.timer_delay),
  .out_last  (out_o.last)
);

### test/sorted_sleep_timer_queue_core_tb.sv
// sorted_sleep_timer_queue_core_tb: checks enqueue, cancel and timer results against a
// sleeper list tracked in the bench; directed cases, random phases, fill and back-pressure
// depends on sstq_pkg, the three channel interfaces and sorted_sleep_timer_queue_core
`timescale 1ns / 100ps

module sorted_sleep_timer_queue_core_tb;
  import sstq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [TICK_W-1:0]    TICK_MAX    = '1;

  typedef struct {
    func_e             func;
    logic [TID_W-1:0]  thread_id;
    logic [SEC_W-1:0]  timeout_sec;
    logic [NSEC_W-1:0] timeout_nsec;
    logic [TICK_W-1:0] now_tick;
  } sleep_req_t;

  typedef struct {
    kind_e             kind;
    logic [TID_W-1:0]  woken_id;
    logic              set_timer;
    logic [TICK_W-1:0] timer_delay;
    logic              last;
  } timer_evt_t;

  logic clk_i;
  logic rst_ni;

  sstq_in_if  in_if ();
  sstq_out_if out_if ();
  sstq_cfg_if cfg_if ();

  sorted_sleep_timer_queue_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // sleeper list as the block should hold it
  logic [TICK_W-1:0] q_tick [QUEUE_DEPTH];
  logic [TID_W-1:0]  q_id   [QUEUE_DEPTH];
  int                q_count     = 0;
  logic [TICK_W-1:0] next_expiry = '0;
  logic [TPM_W-1:0]  tpm_reg     = 10'd1;
  logic [PER_W-1:0]  period_reg  = 32'd10000;

  timer_evt_t        pending_events[$];
  int unsigned       mismatch_count = 0;
  int unsigned       in_idle_pct    = 0;
  int unsigned       out_stall_pct  = 0;
  int unsigned       hold_left      = 0;
  logic [TICK_W-1:0] now_base       = '0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic sleep_req_t make_req(input func_e f, input logic [TID_W-1:0] id,
                                          input logic [SEC_W-1:0] sec,
                                          input logic [NSEC_W-1:0] nsec,
                                          input logic [TICK_W-1:0] now);
    sleep_req_t r;
    r.func         = f;
    r.thread_id    = id;
    r.timeout_sec  = sec;
    r.timeout_nsec = nsec;
    r.now_tick     = now;
    return r;
  endfunction

  function automatic void add_event(input kind_e kind, input logic [TID_W-1:0] id,
                                    input logic set, input logic [TICK_W-1:0] delay,
                                    input logic last);
    timer_evt_t e;
    e.kind        = kind;
    e.woken_id    = id;
    e.set_timer   = set;
    e.timer_delay = delay;
    e.last        = last;
    pending_events.push_back(e);
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_tick[i] = q_tick[i+1];
      q_id[i]   = q_id[i+1];
    end
    q_count--;
  endfunction

  function automatic void predict_queue_events(input sleep_req_t r);
    logic [TICK_W-1:0] ticks;
    logic [TICK_W-1:0] wake;
    logic [TICK_W-1:0] delay;
    int                pos;
    case (r.func)
      F_ENQ: begin
        if (q_count >= QUEUE_DEPTH) begin
          add_event(K_FULL, r.thread_id, 1'b0, '0, 1'b1);
        end else begin
          ticks = (TICK_W'(r.timeout_sec) * 64'd1_000_000 + TICK_W'(r.timeout_nsec) / 64'd1000)
                  * TICK_W'(tpm_reg);
          wake  = r.now_tick + ticks;
          pos   = 0;
          while (pos < q_count && q_tick[pos] <= wake) pos++;
          for (int i = q_count; i > pos; i--) begin
            q_tick[i] = q_tick[i-1];
            q_id[i]   = q_id[i-1];
          end
          q_tick[pos] = wake;
          q_id[pos]   = r.thread_id;
          q_count++;
          if (next_expiry > wake) begin
            next_expiry = wake;
            add_event(K_ENQ, r.thread_id, 1'b1, ticks, 1'b1);
          end else begin
            add_event(K_ENQ, r.thread_id, 1'b0, '0, 1'b1);
          end
        end
      end
      F_CANCEL: begin
        pos = 0;
        while (pos < q_count && q_id[pos] != r.thread_id) pos++;
        if (pos < q_count) begin
          drop_entry(pos);
          add_event(K_CANCEL, r.thread_id, 1'b0, '0, 1'b1);
        end else begin
          add_event(K_NOTFOUND, r.thread_id, 1'b0, '0, 1'b1);
        end
      end
      F_TIMER: begin
        while (q_count > 0 && q_tick[0] <= r.now_tick) begin
          add_event(K_WOKEN, q_id[0], 1'b0, '0, 1'b0);
          drop_entry(0);
        end
        delay = TICK_W'(period_reg);
        wake  = r.now_tick + delay;
        if (q_count > 0 && wake > q_tick[0]) begin
          delay = (q_tick[0] > r.now_tick) ? q_tick[0] - r.now_tick : '0;
        end
        next_expiry = r.now_tick + delay;
        add_event(K_REARM, '0, 1'b1, delay, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  // mostly well-formed traffic around a moving tick base, some full-range noise
  function automatic sleep_req_t random_request();
    sleep_req_t  r;
    int unsigned sel;
    sel = $urandom_range(99);
    r = make_req(F_ENQ, TID_W'($urandom), '0, NSEC_W'($urandom_range(999_999_999)), now_base);
    if ($urandom_range(1) == 0) r.thread_id = TID_W'($urandom_range(15));
    if (sel < 45) begin
      if ($urandom_range(3) == 0) r.timeout_sec = SEC_W'($urandom_range(3));
      if ($urandom_range(7) == 0) r.now_tick = now_base + TICK_W'($urandom_range(5000));
    end else if (sel < 65) begin
      r.func = F_CANCEL;
      if (q_count > 0 && $urandom_range(3) != 0) r.thread_id = q_id[$urandom_range(q_count-1)];
    end else if (sel < 90) begin
      r.func     = F_TIMER;
      now_base   = now_base + TICK_W'($urandom_range(1_500_000)) * TICK_W'(tpm_reg);
      r.now_tick = now_base;
    end else begin
      r.func         = func_e'($urandom_range(3));
      r.timeout_sec  = $urandom;
      r.timeout_nsec = NSEC_W'($urandom);
      r.now_tick     = {$urandom, $urandom};
    end
    return r;
  endfunction

  task automatic send_item(input sleep_req_t r);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk_i);
    in_if.valid        = 1'b1;
    in_if.func         = r.func;
    in_if.thread_id    = r.thread_id;
    in_if.timeout_sec  = r.timeout_sec;
    in_if.timeout_nsec = r.timeout_nsec;
    in_if.now_tick     = r.now_tick;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_queue_events(r);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_TPM:    tpm_reg = val[TPM_W-1:0];
      CFG_PERIOD: period_reg = val;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_queue_drained();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_item(make_req(F_CANCEL, 8'h00, '0, '0, '0));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, '0));
    send_item(make_req(F_ENQ, 8'hFF, '0, '0, '0));
    send_item(make_req(F_ENQ, 8'h00, '0, 30'd999, 64'd5));
    // equal wakeup tick goes behind the earlier entry
    send_item(make_req(F_ENQ, 8'h11, '0, '0, 64'd5));
    send_item(make_req(F_ENQ, 8'h5A, '0, 30'd999_999_999, '0));
    send_item(make_req(F_ENQ, 8'h5A, 32'd1, '0, '0));
    // wakeup tick wraps past 2^64
    send_item(make_req(F_ENQ, 8'hA5, 32'hFFFF_FFFF, 30'h3FFF_FFFF, TICK_MAX));
    send_item(make_req(F_CANCEL, 8'h5A, '0, '0, '0));
    send_item(make_req(F_CANCEL, 8'h77, '0, '0, '0));
    send_item(make_req(F_NONE, 8'hC3, $urandom, NSEC_W'($urandom), {$urandom, $urandom}));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, 64'd5));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, TICK_MAX));
    wait_queue_drained();
    write_reg(CFG_TPM, '0);
    write_reg(CFG_PERIOD, '0);
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    send_item(make_req(F_ENQ, 8'h01, 32'd5, 30'd7000, 64'd100));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, 64'd50));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, 64'd100));
    wait_queue_drained();
    write_reg(CFG_TPM, 32'hFFFF_FFFF);
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    send_item(make_req(F_ENQ, 8'h02, 32'hFFFF_FFFF, 30'd999_999_999, '0));
    send_item(make_req(F_ENQ, 8'h03, '0, 30'd1000, 64'hFFFF_FFFF_FFFF_0000));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, 64'hFFFF_FFFF_FFFF_0000));
    send_item(make_req(F_TIMER, 8'h00, '0, '0, TICK_MAX));
    wait_queue_drained();
    // upper data bits beyond the register width are dropped
    write_reg(CFG_TPM, 32'hFFFF_FC01);
    write_reg(CFG_PERIOD, 32'd10000);
  endtask

  task automatic test_random_phases();
    now_base = TICK_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      wait_queue_drained();
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          write_reg(CFG_TPM, 32'd1);
          write_reg(CFG_PERIOD, 32'd10000);
        end
        1: begin
          in_idle_pct   = 51;
          out_stall_pct = 0;
          write_reg(CFG_TPM, 32'd1023);
          write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 51;
          write_reg(CFG_TPM, CFG_DATA_W'($urandom_range(1, 1023)));
          write_reg(CFG_PERIOD, $urandom);
        end
        default: begin
          in_idle_pct   = 6;
          out_stall_pct = 6;
          write_reg(CFG_TPM, CFG_DATA_W'($urandom_range(1, 8)));
          write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(1, 5000)));
        end
      endcase
      repeat (30) send_item(random_request());
    end
  endtask

  task automatic test_fill_and_flush();
    in_idle_pct   = 6;
    out_stall_pct = 6;
    while (q_count < QUEUE_DEPTH) begin
      send_item(make_req(F_ENQ, TID_W'($urandom), '0, NSEC_W'($urandom_range(999_999_999)),
                         now_base));
    end
    repeat (2) send_item(make_req(F_ENQ, TID_W'($urandom), $urandom, '0, now_base));
    send_item(make_req(F_CANCEL, q_id[$urandom_range(QUEUE_DEPTH-1)], '0, '0, now_base));
    send_item(make_req(F_ENQ, TID_W'($urandom), '0, '0, now_base));
    // every sleeper is due at the top tick
    send_item(make_req(F_TIMER, 8'h00, '0, '0, TICK_MAX));
    wait_queue_drained();
  endtask

  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    @(posedge clk_i);
    hold_left = 400;
    @(negedge clk_i);
    repeat (16) send_item(random_request());
    wait_queue_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    timer_evt_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        $error("result with nothing expected: kind %0d id %0h", out_if.kind, out_if.woken_id);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_if.kind);
          mismatch_count++;
        end
        if (out_if.woken_id !== want.woken_id) begin
          $error("woken_id: expected %0h, actual %0h", want.woken_id, out_if.woken_id);
          mismatch_count++;
        end
        if (out_if.set_timer !== want.set_timer) begin
          $error("set_timer: expected %0d, actual %0d", want.set_timer, out_if.set_timer);
          mismatch_count++;
        end
        if (out_if.timer_delay !== want.timer_delay) begin
          $error("timer_delay: expected %0h, actual %0h", want.timer_delay, out_if.timer_delay);
          mismatch_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_if.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = F_ENQ;
    in_if.thread_id    = '0;
    in_if.timeout_sec  = '0;
    in_if.timeout_nsec = '0;
    in_if.now_tick     = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_TPM;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phases();
    test_fill_and_flush();
    test_backpressure();

    in_idle_pct   = 0;
    out_stall_pct = 0;
    wait_queue_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/sstq_pkg.sv
design/sstq_in_if.sv
design/sstq_out_if.sv
design/sstq_cfg_if.sv
design/sstq_cell.sv
design/sstq_chain.sv
design/sorted_sleep_timer_queue_core.sv
design/sstq_checker.sv
test/sorted_sleep_timer_queue_core_tb.sv
